>>> design/ptc_pkg.sv
// Shared types and constants of the pressure and temperature compensation pipeline.
// Used by every module of the block; depends on nothing.
package ptc_pkg;

    localparam int PIPE_DEPTH   = 12;
    localparam int TEMP_STAGES  = 6;
    localparam int PRES_STAGES  = PIPE_DEPTH - TEMP_STAGES;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int RAW_W        = 24;
    localparam int TEMP_W       = 19;
    localparam int PRES_W       = 21;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_MODEL_SELECT  = 3'd0;
    localparam cfg_idx_t REG_PRES_SENS     = 3'd1;
    localparam cfg_idx_t REG_PRES_OFFSET   = 3'd2;
    localparam cfg_idx_t REG_SENS_TCOEFF   = 3'd3;
    localparam cfg_idx_t REG_OFFSET_TCOEFF = 3'd4;
    localparam cfg_idx_t REG_REF_TEMP      = 3'd5;
    localparam cfg_idx_t REG_TEMP_SLOPE    = 3'd6;

    typedef struct packed {
        logic        two_bar;
        logic [15:0] c1;
        logic [15:0] c2;
        logic [15:0] c3;
        logic [15:0] c4;
        logic [15:0] c5;
        logic [15:0] c6;
    } cal_t;

    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 19'sd200000;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -19'sd200000;
    localparam logic signed [PRES_W-1:0] PRES_MAX = 21'sd1000000;
    localparam logic signed [PRES_W-1:0] PRES_MIN = -21'sd1000000;

    localparam logic signed [18:0] TEMP_REF      = 19'sd2000;
    localparam logic signed [18:0] TEMP_VLOW     = -19'sd1500;
    localparam logic signed [19:0] TEMP_VLOW_OFS = 20'sd1500;

    // limits applied before the final divide by 10 or 100
    localparam logic [26:0] PRE_LIM_30BAR = 27'd10000009;
    localparam logic [26:0] PRE_LIM_2BAR  = 27'd100000099;

    // ceil(2^34 / d) for d = 10 and d = 100
    localparam logic [30:0] RECIP_10    = 31'd1717986919;
    localparam logic [30:0] RECIP_100   = 31'd171798692;
    localparam int          RECIP_SHIFT = 34;

endpackage

>>> design/pressure_temperature_compensation.sv
// Second-order pressure and temperature compensation for a 30 bar or 2 bar
// pressure sensor. Each transfer in carries raw 24-bit pressure and temperature
// conversions; each transfer out gives temperature in 0.01 degC and pressure in
// mbar, both saturated. The datapath is a 12-stage pipeline: a new reading is
// taken every cycle while s_ready is high. Any empty stage absorbs a stall, so
// s_ready drops only when all 12 stages hold data and m_ready is low. Write
// calibration registers while idle.
module pressure_temperature_compensation (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  ptc_pkg::cfg_idx_t                   cfg_index,
    input  logic [ptc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ptc_pkg::RAW_W-1:0]           s_raw_pressure,
    input  logic [ptc_pkg::RAW_W-1:0]           s_raw_temperature,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ptc_pkg::TEMP_W-1:0]   m_temperature_centi,
    output logic signed [ptc_pkg::PRES_W-1:0]   m_pressure_mbar
);
    import ptc_pkg::*;

    cal_t                   cal;
    logic [PIPE_DEPTH-1:0]  stage_en;
    logic [RAW_W-1:0]       d1;
    logic signed [TEMP_W-1:0] temp_sat;
    logic signed [39:0]     off_val;
    logic signed [39:0]     sens_val;

    ptc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cal       (cal)
    );

    ptc_pipe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .stage_en (stage_en)
    );

    ptc_temp_path u_temp (
        .aclk              (aclk),
        .stage_en          (stage_en[TEMP_STAGES-1:0]),
        .cal               (cal),
        .s_raw_pressure    (s_raw_pressure),
        .s_raw_temperature (s_raw_temperature),
        .d1                (d1),
        .temp_sat          (temp_sat),
        .off_val           (off_val),
        .sens_val          (sens_val)
    );

    ptc_pres_path u_pres (
        .aclk                (aclk),
        .stage_en            (stage_en[PIPE_DEPTH-1:TEMP_STAGES]),
        .cal                 (cal),
        .d1                  (d1),
        .temp_sat            (temp_sat),
        .off_val             (off_val),
        .sens_val            (sens_val),
        .m_temperature_centi (m_temperature_centi),
        .m_pressure_mbar     (m_pressure_mbar)
    );

`ifndef NO_ASSERTIONS
    a_ready_when_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled while output stage can drain");

    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_temperature_centi >= TEMP_MIN && m_temperature_centi <= TEMP_MAX))
        else $error("temperature outside saturation range");

    a_pres_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pressure_mbar >= PRES_MIN && m_pressure_mbar <= PRES_MAX))
        else $error("pressure outside saturation range");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");
`endif

endmodule

>>> design/ptc_cfg_regs.sv
// Calibration and model select registers, written through the plain write port.
// Depends on ptc_pkg.
module ptc_cfg_regs (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  ptc_pkg::cfg_idx_t                      cfg_index,
    input  logic [ptc_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    output ptc_pkg::cal_t                          cal
);
    import ptc_pkg::*;

    cal_t cal_reg;
    cal_t cal_next;

    always_comb begin
        cal_next = cal_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_MODEL_SELECT:  cal_next.two_bar = cfg_wdata[0];
                REG_PRES_SENS:     cal_next.c1 = cfg_wdata;
                REG_PRES_OFFSET:   cal_next.c2 = cfg_wdata;
                REG_SENS_TCOEFF:   cal_next.c3 = cfg_wdata;
                REG_OFFSET_TCOEFF: cal_next.c4 = cfg_wdata;
                REG_REF_TEMP:      cal_next.c5 = cfg_wdata;
                REG_TEMP_SLOPE:    cal_next.c6 = cfg_wdata;
                default:           cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else begin
            cal_reg <= cal_next;
        end
    end

    assign cal = cal_reg;

endmodule

>>> design/ptc_pipe_ctrl.sv
// Valid bits and per-stage load enables of the compensation pipeline.
// A stage loads when it is empty or some later stage, or the output, can move.
// Depends on ptc_pkg.
module ptc_pipe_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ptc_pkg::PIPE_DEPTH-1:0]  stage_en
);
    import ptc_pkg::*;

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;

    always_comb begin
        logic full;
        for (int i = 0; i < PIPE_DEPTH; i++) begin
            full = 1'b1;
            for (int j = 0; j < PIPE_DEPTH; j++) begin
                if (j >= i) begin
                    full = full & valid_reg[j];
                end
            end
            stage_en[i] = m_ready | ~full;
        end
    end

    always_comb begin
        valid_next[0] = stage_en[0] ? s_valid : valid_reg[0];
        for (int i = 1; i < PIPE_DEPTH; i++) begin
            valid_next[i] = stage_en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = valid_reg[PIPE_DEPTH-1];

endmodule

>>> design/ptc_temp_path.sv
// Stages one to six: dT, first-order temperature, offset and sensitivity,
// second-order corrections and the saturated temperature. Depends on ptc_pkg.
module ptc_temp_path (
    input  logic                                aclk,
    input  logic [ptc_pkg::TEMP_STAGES-1:0]     stage_en,
    input  ptc_pkg::cal_t                       cal,
    input  logic [ptc_pkg::RAW_W-1:0]           s_raw_pressure,
    input  logic [ptc_pkg::RAW_W-1:0]           s_raw_temperature,
    output logic [ptc_pkg::RAW_W-1:0]           d1,
    output logic signed [ptc_pkg::TEMP_W-1:0]   temp_sat,
    output logic signed [39:0]                  off_val,
    output logic signed [39:0]                  sens_val
);
    import ptc_pkg::*;

    // stage 0
    logic signed [24:0] dt_s0_reg, dt_s0_next;
    logic [23:0]        d1_s0_reg;
    // stage 1
    logic signed [41:0] tq_s1_reg, tq_s1_next;
    logic signed [41:0] sp_s1_reg, sp_s1_next;
    logic signed [41:0] op_s1_reg, op_s1_next;
    logic [47:0]        dtsq_s1_reg, dtsq_s1_next;
    logic [23:0]        d1_s1_reg;
    // stage 2
    logic signed [17:0] dev_s2_reg, dev_s2_next;
    logic signed [18:0] temp1_s2_reg, temp1_s2_next;
    logic signed [35:0] sens1_s2_reg, sens1_s2_next;
    logic signed [36:0] off1_s2_reg, off1_s2_next;
    logic [47:0]        dtsq_s2_reg;
    logic [23:0]        d1_s2_reg;
    // stage 3
    logic               low_s3_reg, low_s3_next;
    logic               vlow_s3_reg, vlow_s3_next;
    logic [16:0]        ti_s3_reg, ti_s3_next;
    logic [33:0]        dev2_s3_reg, dev2_s3_next;
    logic [34:0]        vsq_s3_reg, vsq_s3_next;
    logic signed [18:0] temp1_s3_reg;
    logic signed [35:0] sens1_s3_reg;
    logic signed [36:0] off1_s3_reg;
    logic [23:0]        d1_s3_reg;
    // stage 4
    logic [38:0]        offi_s4_reg, offi_s4_next;
    logic [38:0]        sensi_s4_reg, sensi_s4_next;
    logic signed [18:0] temp_s4_reg, temp_s4_next;
    logic signed [35:0] sens1_s4_reg;
    logic signed [36:0] off1_s4_reg;
    logic [23:0]        d1_s4_reg;
    // stage 5
    logic signed [39:0] off2_s5_reg, off2_s5_next;
    logic signed [39:0] sens2_s5_reg, sens2_s5_next;
    logic signed [18:0] temp_s5_reg;
    logic [23:0]        d1_s5_reg;

    always_comb begin
        dt_s0_next = signed'({1'b0, s_raw_temperature}) - signed'({1'b0, cal.c5, 8'b0});
    end

    always_comb begin
        logic signed [16:0] c6_s;
        logic signed [16:0] c3_s;
        logic signed [16:0] c4_s;
        logic signed [49:0] sq;
        c6_s = signed'({1'b0, cal.c6});
        c3_s = signed'({1'b0, cal.c3});
        c4_s = signed'({1'b0, cal.c4});
        tq_s1_next   = dt_s0_reg * c6_s;
        sp_s1_next   = dt_s0_reg * c3_s;
        op_s1_next   = dt_s0_reg * c4_s;
        sq           = dt_s0_reg * dt_s0_reg;
        dtsq_s1_next = sq[47:0];
    end

    // truncate toward zero: bias negative values before the arithmetic shift
    always_comb begin
        logic signed [41:0] q;
        logic signed [41:0] sp_d;
        logic signed [41:0] op_d;
        q = (tq_s1_reg + (tq_s1_reg[41] ? 42'sd8388607 : 42'sd0)) >>> 23;
        dev_s2_next   = q[17:0];
        temp1_s2_next = dev_s2_next + TEMP_REF;
        if (cal.two_bar) begin
            sp_d = (sp_s1_reg + (sp_s1_reg[41] ? 42'sd127 : 42'sd0)) >>> 7;
            op_d = (op_s1_reg + (op_s1_reg[41] ? 42'sd63 : 42'sd0)) >>> 6;
            sens1_s2_next = signed'({4'b0, cal.c1, 16'b0}) + signed'(sp_d[35:0]);
            off1_s2_next  = signed'({4'b0, cal.c2, 17'b0}) + signed'(op_d[36:0]);
        end else begin
            sp_d = (sp_s1_reg + (sp_s1_reg[41] ? 42'sd255 : 42'sd0)) >>> 8;
            op_d = (op_s1_reg + (op_s1_reg[41] ? 42'sd127 : 42'sd0)) >>> 7;
            sens1_s2_next = signed'({5'b0, cal.c1, 15'b0}) + signed'(sp_d[35:0]);
            off1_s2_next  = signed'({5'b0, cal.c2, 16'b0}) + signed'(op_d[36:0]);
        end
    end

    always_comb begin
        logic signed [35:0] dsq;
        logic signed [19:0] v;
        logic signed [39:0] vq;
        logic [51:0]        t11;
        logic [49:0]        t3;
        dsq          = dev_s2_reg * dev_s2_reg;
        dev2_s3_next = dsq[33:0];
        v            = temp1_s2_reg + TEMP_VLOW_OFS;
        vq           = v * v;
        vsq_s3_next  = vq[34:0];
        low_s3_next  = temp1_s2_reg < TEMP_REF;
        vlow_s3_next = temp1_s2_reg < TEMP_VLOW;
        t11 = {1'b0, dtsq_s2_reg, 3'b0} + {3'b0, dtsq_s2_reg, 1'b0} + {4'b0, dtsq_s2_reg};
        t3  = {1'b0, dtsq_s2_reg, 1'b0} + {2'b0, dtsq_s2_reg};
        if (cal.two_bar) begin
            ti_s3_next = low_s3_next ? t11[51:35] : 17'd0;
        end else if (low_s3_next) begin
            ti_s3_next = t3[49:33];
        end else begin
            ti_s3_next = {5'b0, dtsq_s2_reg[47:36]};
        end
    end

    always_comb begin
        logic [39:0]        d31;
        logic [39:0]        d63;
        logic [39:0]        d3;
        logic [39:0]        d5;
        logic [39:0]        v7;
        logic [39:0]        v4;
        logic signed [19:0] t2;
        d31 = {1'b0, dev2_s3_reg, 5'b0} - {6'b0, dev2_s3_reg};
        d63 = {dev2_s3_reg, 6'b0} - {6'b0, dev2_s3_reg};
        d3  = {5'b0, dev2_s3_reg, 1'b0} + {6'b0, dev2_s3_reg};
        d5  = {4'b0, dev2_s3_reg, 2'b0} + {6'b0, dev2_s3_reg};
        v7  = vlow_s3_reg ? ({2'b0, vsq_s3_reg, 3'b0} - {5'b0, vsq_s3_reg}) : 40'd0;
        v4  = vlow_s3_reg ? {3'b0, vsq_s3_reg, 2'b0} : 40'd0;
        if (!low_s3_reg) begin
            offi_s4_next  = cal.two_bar ? 39'd0 : {9'b0, dev2_s3_reg[33:4]};
            sensi_s4_next = 39'd0;
        end else if (cal.two_bar) begin
            offi_s4_next  = {3'b0, d31[38:3]};
            sensi_s4_next = {1'b0, d63[39:5], 3'b0} >> 3;
        end else begin
            offi_s4_next  = {1'b0, d3[38:1]} + v7[38:0];
            sensi_s4_next = {3'b0, d5[38:3]} + v4[38:0];
        end
        t2 = temp1_s3_reg - signed'({3'b0, ti_s3_reg});
        if (t2 > TEMP_MAX) begin
            temp_s4_next = TEMP_MAX;
        end else if (t2 < TEMP_MIN) begin
            temp_s4_next = TEMP_MIN;
        end else begin
            temp_s4_next = t2[18:0];
        end
    end

    always_comb begin
        off2_s5_next  = off1_s4_reg - signed'({1'b0, offi_s4_reg});
        sens2_s5_next = sens1_s4_reg - signed'({1'b0, sensi_s4_reg});
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            dt_s0_reg <= dt_s0_next;
            d1_s0_reg <= s_raw_pressure;
        end
        if (stage_en[1]) begin
            tq_s1_reg   <= tq_s1_next;
            sp_s1_reg   <= sp_s1_next;
            op_s1_reg   <= op_s1_next;
            dtsq_s1_reg <= dtsq_s1_next;
            d1_s1_reg   <= d1_s0_reg;
        end
        if (stage_en[2]) begin
            dev_s2_reg   <= dev_s2_next;
            temp1_s2_reg <= temp1_s2_next;
            sens1_s2_reg <= sens1_s2_next;
            off1_s2_reg  <= off1_s2_next;
            dtsq_s2_reg  <= dtsq_s1_reg;
            d1_s2_reg    <= d1_s1_reg;
        end
        if (stage_en[3]) begin
            low_s3_reg   <= low_s3_next;
            vlow_s3_reg  <= vlow_s3_next;
            ti_s3_reg    <= ti_s3_next;
            dev2_s3_reg  <= dev2_s3_next;
            vsq_s3_reg   <= vsq_s3_next;
            temp1_s3_reg <= temp1_s2_reg;
            sens1_s3_reg <= sens1_s2_reg;
            off1_s3_reg  <= off1_s2_reg;
            d1_s3_reg    <= d1_s2_reg;
        end
        if (stage_en[4]) begin
            offi_s4_reg  <= offi_s4_next;
            sensi_s4_reg <= sensi_s4_next;
            temp_s4_reg  <= temp_s4_next;
            sens1_s4_reg <= sens1_s3_reg;
            off1_s4_reg  <= off1_s3_reg;
            d1_s4_reg    <= d1_s3_reg;
        end
        if (stage_en[5]) begin
            off2_s5_reg  <= off2_s5_next;
            sens2_s5_reg <= sens2_s5_next;
            temp_s5_reg  <= temp_s4_reg;
            d1_s5_reg    <= d1_s4_reg;
        end
    end

    assign d1       = d1_s5_reg;
    assign temp_sat = temp_s5_reg;
    assign off_val  = off2_s5_reg;
    assign sens_val = sens2_s5_reg;

endmodule

>>> design/ptc_pres_path.sv
// Stages seven to twelve: split multiply of raw pressure by sensitivity, offset
// removal, scaling, saturation and the final divide by 10 or 100. Depends on ptc_pkg.
module ptc_pres_path (
    input  logic                                aclk,
    input  logic [ptc_pkg::PRES_STAGES-1:0]     stage_en,
    input  ptc_pkg::cal_t                       cal,
    input  logic [ptc_pkg::RAW_W-1:0]           d1,
    input  logic signed [ptc_pkg::TEMP_W-1:0]   temp_sat,
    input  logic signed [39:0]                  off_val,
    input  logic signed [39:0]                  sens_val,
    output logic signed [ptc_pkg::TEMP_W-1:0]   m_temperature_centi,
    output logic signed [ptc_pkg::PRES_W-1:0]   m_pressure_mbar
);
    import ptc_pkg::*;

    // stage 6
    logic [43:0]        pp_lo_reg, pp_lo_next;
    logic signed [44:0] pp_hi_reg, pp_hi_next;
    logic signed [39:0] off_s6_reg;
    logic signed [18:0] temp_s6_reg;
    // stage 7
    logic signed [64:0] prod_reg, prod_next;
    logic signed [39:0] off_s7_reg;
    logic signed [18:0] temp_s7_reg;
    // stage 8
    logic signed [44:0] y_reg, y_next;
    logic signed [18:0] temp_s8_reg;
    // stage 9
    logic [26:0]        mag_reg, mag_next;
    logic               neg_s9_reg, neg_s9_next;
    logic signed [18:0] temp_s9_reg;
    // stage 10
    logic [53:0]        rprod_reg, rprod_next;
    logic               neg_s10_reg;
    logic signed [18:0] temp_s10_reg;
    // stage 11
    logic signed [20:0] pres_out_reg, pres_out_next;
    logic signed [18:0] temp_out_reg;

    always_comb begin
        logic signed [24:0] d1_s;
        logic signed [19:0] hi_s;
        d1_s       = signed'({1'b0, d1});
        hi_s       = signed'(sens_val[39:20]);
        pp_lo_next = d1 * sens_val[19:0];
        pp_hi_next = d1_s * hi_s;
    end

    always_comb begin
        logic signed [64:0] hi_ext;
        hi_ext    = pp_hi_reg;
        prod_next = (hi_ext <<< 20) + signed'({21'b0, pp_lo_reg});
    end

    always_comb begin
        logic signed [64:0] q21;
        q21    = (prod_reg + (prod_reg[64] ? 65'sd2097151 : 65'sd0)) >>> 21;
        y_next = signed'(q21[44:0]) - off_s7_reg;
    end

    // saturate ahead of the final divide, then hold sign and magnitude
    always_comb begin
        logic signed [44:0] z;
        logic signed [44:0] lim;
        logic signed [44:0] z_abs;
        if (cal.two_bar) begin
            z   = (y_reg + (y_reg[44] ? 45'sd32767 : 45'sd0)) >>> 15;
            lim = signed'({18'b0, PRE_LIM_2BAR});
        end else begin
            z   = (y_reg + (y_reg[44] ? 45'sd8191 : 45'sd0)) >>> 13;
            lim = signed'({18'b0, PRE_LIM_30BAR});
        end
        z_abs = z[44] ? -z : z;
        if (z > lim) begin
            mag_next    = lim[26:0];
            neg_s9_next = 1'b0;
        end else if (z < -lim) begin
            mag_next    = lim[26:0];
            neg_s9_next = 1'b1;
        end else begin
            mag_next    = z_abs[26:0];
            neg_s9_next = z[44];
        end
    end

    always_comb begin
        logic [30:0] recip;
        recip      = cal.two_bar ? RECIP_100 : RECIP_10;
        rprod_next = mag_reg * recip;
    end

    always_comb begin
        logic signed [20:0] res;
        res           = signed'({1'b0, rprod_reg[RECIP_SHIFT+19:RECIP_SHIFT]});
        pres_out_next = neg_s10_reg ? -res : res;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            pp_lo_reg   <= pp_lo_next;
            pp_hi_reg   <= pp_hi_next;
            off_s6_reg  <= off_val;
            temp_s6_reg <= temp_sat;
        end
        if (stage_en[1]) begin
            prod_reg    <= prod_next;
            off_s7_reg  <= off_s6_reg;
            temp_s7_reg <= temp_s6_reg;
        end
        if (stage_en[2]) begin
            y_reg       <= y_next;
            temp_s8_reg <= temp_s7_reg;
        end
        if (stage_en[3]) begin
            mag_reg     <= mag_next;
            neg_s9_reg  <= neg_s9_next;
            temp_s9_reg <= temp_s8_reg;
        end
        if (stage_en[4]) begin
            rprod_reg    <= rprod_next;
            neg_s10_reg  <= neg_s9_reg;
            temp_s10_reg <= temp_s9_reg;
        end
        if (stage_en[5]) begin
            pres_out_reg <= pres_out_next;
            temp_out_reg <= temp_s10_reg;
        end
    end

    assign m_temperature_centi = temp_out_reg;
    assign m_pressure_mbar     = pres_out_reg;

endmodule

>>> test/tb_pressure_temperature_compensation.sv
`timescale 1ns / 1ps
// Self-checking testbench for pressure_temperature_compensation: raw readings go in by
// valid/ready, each compensated reading is predicted here and checked field by field.
// Depends on ptc_pkg and the block's RTL only.
module tb_pressure_temperature_compensation;
    import ptc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 100;
    localparam int unsigned PHASES      = 10;
    localparam int unsigned PHASE_ITEMS = 124;
    localparam int unsigned HOLD_PHASE  = 7;
    localparam int unsigned MAX_REPORTS = 200;

    localparam cfg_idx_t REG_UNMAPPED = 3'd7;

    localparam longint SCALE_2_21 = 64'sd2097152;
    localparam longint SCALE_2_23 = 64'sd8388608;
    localparam longint SCALE_2_33 = 64'sd8589934592;
    localparam longint SCALE_2_35 = 64'sd34359738368;
    localparam longint SCALE_2_37 = 64'sd137438953472;

    typedef enum int {
        CAL_NEAR_TYPICAL,
        CAL_ALL_ONES,
        CAL_ALL_ZERO,
        CAL_MIXED_EXTREMES,
        CAL_RANDOM
    } cal_style_e;

    typedef struct packed {
        logic [RAW_W-1:0] pressure;
        logic [RAW_W-1:0] temperature;
    } raw_reading_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_centi;
        logic signed [PRES_W-1:0] pres_mbar;
    } comp_reading_t;

    logic                        aclk              = 1'b0;
    logic                        aresetn           = 1'b0;
    logic                        cfg_wr_en         = 1'b0;
    cfg_idx_t                    cfg_index         = '0;
    logic [CFG_DATA_W-1:0]       cfg_wdata         = '0;
    logic                        s_valid           = 1'b0;
    logic                        s_ready;
    logic [RAW_W-1:0]            s_raw_pressure    = '0;
    logic [RAW_W-1:0]            s_raw_temperature = '0;
    logic                        m_valid;
    logic                        m_ready           = 1'b0;
    logic signed [TEMP_W-1:0]    m_temperature_centi;
    logic signed [PRES_W-1:0]    m_pressure_mbar;

    cal_t            cal_shadow = '0;
    raw_reading_t    raw_queue[$];
    comp_reading_t   pending_readings[$];
    raw_reading_t    next_raw;
    comp_reading_t   want;
    bit              src_idle_on  = 1'b1;
    bit              sink_idle_on = 1'b1;
    int unsigned     send_gap     = 0;
    int unsigned     sink_gap     = 0;
    int unsigned     hold_req     = 0;
    int unsigned     hold_ack     = 0;
    int unsigned     hold_left    = 0;
    int unsigned     sent_cnt     = 0;
    int unsigned     error_cnt    = 0;
    int unsigned     cal_loads    = 0;
    int unsigned     cycle_cnt    = 0;

    pressure_temperature_compensation i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_raw_pressure      (s_raw_pressure),
        .s_raw_temperature   (s_raw_temperature),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_temperature_centi (m_temperature_centi),
        .m_pressure_mbar     (m_pressure_mbar)
    );

    always #5 aclk = ~aclk;

    function automatic comp_reading_t compensate(raw_reading_t raw);
        longint d1, d2, c1, c2, c3, c4, c5, c6;
        longint dt, temp, off, sens, ti, offi, sensi, dev, dev2, low, pres;
        comp_reading_t r;
        d1 = longint'(raw.pressure);
        d2 = longint'(raw.temperature);
        c1 = longint'(cal_shadow.c1);
        c2 = longint'(cal_shadow.c2);
        c3 = longint'(cal_shadow.c3);
        c4 = longint'(cal_shadow.c4);
        c5 = longint'(cal_shadow.c5);
        c6 = longint'(cal_shadow.c6);
        ti = 0;
        offi = 0;
        sensi = 0;
        dt = d2 - c5 * 256;
        temp = 2000 + (dt * c6) / SCALE_2_23;
        if (cal_shadow.two_bar) begin
            sens = c1 * 65536 + (c3 * dt) / 128;
            off = c2 * 131072 + (c4 * dt) / 64;
        end else begin
            sens = c1 * 32768 + (c3 * dt) / 256;
            off = c2 * 65536 + (c4 * dt) / 128;
        end
        dev = temp - 2000;
        dev2 = dev * dev;
        if (cal_shadow.two_bar) begin
            if (temp < 2000) begin
                ti = (11 * dt * dt) / SCALE_2_35;
                offi = (31 * dev2) / 8;
                sensi = (63 * dev2) / 32;
            end
        end else if (temp < 2000) begin
            ti = (3 * dt * dt) / SCALE_2_33;
            offi = (3 * dev2) / 2;
            sensi = (5 * dev2) / 8;
            if (temp < -1500) begin
                low = temp + 1500;
                offi = offi + 7 * low * low;
                sensi = sensi + 4 * low * low;
            end
        end else begin
            ti = (2 * dt * dt) / SCALE_2_37;
            offi = dev2 / 16;
        end
        off = off - offi;
        sens = sens - sensi;
        temp = temp - ti;
        if (cal_shadow.two_bar)
            pres = (((d1 * sens) / SCALE_2_21 - off) / 32768) / 100;
        else
            pres = (((d1 * sens) / SCALE_2_21 - off) / 8192) / 10;
        if (temp > TEMP_MAX) temp = TEMP_MAX;
        else if (temp < TEMP_MIN) temp = TEMP_MIN;
        if (pres > PRES_MAX) pres = PRES_MAX;
        else if (pres < PRES_MIN) pres = PRES_MIN;
        r.temp_centi = temp[TEMP_W-1:0];
        r.pres_mbar = pres[PRES_W-1:0];
        return r;
    endfunction

    function automatic cal_t typical_cal(bit two_bar);
        if (two_bar)
            return {1'b1, 16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165};
        return {1'b0, 16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146};
    endfunction

    function automatic cal_t random_cal(cal_style_e style, bit two_bar);
        cal_t cal;
        cal = typical_cal(two_bar);
        for (int i = 0; i < 6; i++) begin
            case (style)
                CAL_NEAR_TYPICAL: begin
                    cal[16*i +: 16] = cal[16*i +: 16] + 16'($urandom_range(0, 2000)) - 16'd1000;
                end
                CAL_ALL_ONES: cal[16*i +: 16] = '1;
                CAL_ALL_ZERO: cal[16*i +: 16] = '0;
                CAL_MIXED_EXTREMES: begin
                    case ($urandom_range(0, 2))
                        0: cal[16*i +: 16] = '0;
                        1: cal[16*i +: 16] = '1;
                        default: cal[16*i +: 16] = 16'($urandom);
                    endcase
                end
                default: cal[16*i +: 16] = 16'($urandom);
            endcase
        end
        cal.two_bar = two_bar;
        return cal;
    endfunction

    function automatic logic [RAW_W-1:0] edge_biased_raw();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return RAW_W'($urandom_range(0, 255));
            3: return ~RAW_W'($urandom_range(0, 255));
            default: return RAW_W'($urandom);
        endcase
    endfunction

    // bias temperature toward the reference so every correction branch is hit
    function automatic raw_reading_t random_reading();
        raw_reading_t r;
        r.pressure = edge_biased_raw();
        if ($urandom_range(0, 1))
            r.temperature = RAW_W'(int'({cal_shadow.c5, 8'd0})
                                   + int'($urandom_range(0, 1 << 22)) - (1 << 21));
        else
            r.temperature = edge_biased_raw();
        return r;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic load_calibration(cal_t cal);
        cfg_idx_t              idx;
        logic [CFG_DATA_W-1:0] word;
        for (int i = 0; i < 8; i++) begin
            idx = cfg_idx_t'(i);
            case (idx)
                REG_MODEL_SELECT:  word = {15'($urandom), cal.two_bar};
                REG_PRES_SENS:     word = cal.c1;
                REG_PRES_OFFSET:   word = cal.c2;
                REG_SENS_TCOEFF:   word = cal.c3;
                REG_OFFSET_TCOEFF: word = cal.c4;
                REG_REF_TEMP:      word = cal.c5;
                REG_TEMP_SLOPE:    word = cal.c6;
                REG_UNMAPPED:      word = 16'($urandom);
                default:           word = '0;
            endcase
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= word;
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cal_shadow = cal;
        cal_loads++;
    endtask

    // sample on the falling edge so every transfer of the rising edge has settled
    task automatic wait_drained();
        @(negedge aclk);
        while (raw_queue.size() != 0 || s_valid || pending_readings.size() != 0)
            @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout with %0d results outstanding", $time,
                     pending_readings.size());
            $display("pressure_temperature_compensation test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                pending_readings.push_back(compensate({s_raw_pressure, s_raw_temperature}));
                sent_cnt <= sent_cnt + 1;
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    s_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (raw_queue.size() != 0) begin
                    next_raw = raw_queue.pop_front();
                    s_valid           <= 1'b1;
                    s_raw_pressure    <= next_raw.pressure;
                    s_raw_temperature <= next_raw.temperature;
                    send_gap          <= src_idle_on ? idle_len() : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_req != hold_ack) begin
            hold_left <= HOLD_CYCLES;
            hold_ack  <= hold_req;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_readings.size() == 0) begin
                    error_cnt = error_cnt + 1;
                    $display("%0t ns: result with nothing expected: temperature %0d, pressure %0d",
                             $time, m_temperature_centi, m_pressure_mbar);
                end else begin
                    want = pending_readings.pop_front();
                    if (m_temperature_centi !== want.temp_centi) begin
                        error_cnt = error_cnt + 1;
                        if (error_cnt <= MAX_REPORTS)
                            $display("%0t ns: temperature_centi expected %0d, actual %0d",
                                     $time, want.temp_centi, m_temperature_centi);
                    end
                    if (m_pressure_mbar !== want.pres_mbar) begin
                        error_cnt = error_cnt + 1;
                        if (error_cnt <= MAX_REPORTS)
                            $display("%0t ns: pressure_mbar expected %0d, actual %0d",
                                     $time, want.pres_mbar, m_pressure_mbar);
                    end
                end
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
            end else if (sink_gap != 0) begin
                m_ready  <= 1'b0;
                sink_gap <= sink_gap - 1;
            end else begin
                m_ready <= 1'b1;
                if (sink_idle_on && $urandom_range(0, 3) == 0)
                    sink_gap <= idle_len();
            end
        end
    end

    initial begin
        raw_reading_t corner [10];
        cal_style_e   style;
        bit           two_bar;
        corner = '{
            {24'd0, 24'd0},
            {24'hFFFFFF, 24'hFFFFFF},
            {24'hFFFFFF, 24'd0},
            {24'd0, 24'hFFFFFF},
            {24'd4958179, 24'd6815414},
            {24'd4958179, 24'd5000000},
            {24'd4958179, 24'd7500000},
            {24'd4958179, 24'd6821376},
            {24'd4958179, 24'd8077568},
            {24'hBC614E, 24'h800000}
        };
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // all-zero calibration straight out of reset
        for (int i = 0; i < 3; i++)
            raw_queue.push_back(corner[i]);
        wait_drained();

        // corner readings on both part types: zero dT, low, very low and high temperature
        for (int m = 0; m < 2; m++) begin
            load_calibration(typical_cal(m[0]));
            foreach (corner[i])
                raw_queue.push_back(corner[i]);
            wait_drained();
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase < 5) begin
                style   = cal_style_e'(phase);
                two_bar = phase[0];
            end else if (phase == 5) begin
                style   = CAL_ALL_ONES;
                two_bar = 1'b0;
            end else begin
                style   = cal_style_e'($urandom_range(0, 4));
                two_bar = $urandom_range(0, 1);
            end
            load_calibration(random_cal(style, two_bar));
            src_idle_on  <= !phase[0];
            sink_idle_on <= !phase[1];
            if (phase == HOLD_PHASE)
                hold_req <= hold_req + 1;
            for (int n = 0; n < PHASE_ITEMS / 2; n++)
                raw_queue.push_back(random_reading());
            if (phase % 3 == 1)
                wait_drained();
            for (int n = PHASE_ITEMS / 2; n < PHASE_ITEMS; n++)
                raw_queue.push_back(random_reading());
            wait_drained();
        end

        repeat (2 * PIPE_DEPTH) @(posedge aclk);
        $display("Run covered %0d readings over %0d calibration loads on both part types,",
                 sent_cnt, cal_loads);
        $display("with a %0d-cycle output hold-off and drained pauses; %0d mismatches.",
                 HOLD_CYCLES, error_cnt);
        if (error_cnt == 0 && pending_readings.size() == 0) begin
            $display("pressure_temperature_compensation test passed");
        end else begin
            $display("pressure_temperature_compensation test failed");
        end
        $finish;
    end

endmodule
